### rtl/spiking_synapse_current_update_defines.svh
// Assertion macros shared by the synaptic current engine.
`ifndef SPIKING_SYNAPSE_CURRENT_UPDATE_DEFINES_SVH
`define SPIKING_SYNAPSE_CURRENT_UPDATE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SSC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/ssc_pkg.sv
// Shared types, constants and helpers of the synaptic current engine.
`timescale 1ns / 1ps

package ssc_pkg;

    localparam int NEURONS_DEF     = 64;
    localparam int WEIGHT_BITS_DEF = 16;
    localparam int INDEX_W         = 6;
    localparam int VALUE_W         = 32;
    localparam int PERIOD_W        = 16;
    localparam int MASK_W          = 64;

    localparam logic [1:0] FUNC_WEIGHT = 2'd0;
    localparam logic [1:0] FUNC_BIAS   = 2'd1;
    localparam logic [1:0] FUNC_TICK   = 2'd2;

    // x*9/10 toward zero: |x| - ceil(|x|/10), with floor(b/10) = (b*RECIP) >> 35
    localparam logic [VALUE_W-1:0] DECAY_RECIP = 32'hCCCC_CCCD;
    localparam logic [VALUE_W-1:0] DECAY_ROUND = 32'd9;
    localparam int                 DECAY_SHIFT = 35;
    localparam int                 DECAY_Q_W   = 2 * VALUE_W - DECAY_SHIFT;

    typedef struct packed {
        logic [1:0]                func;
        logic [INDEX_W-1:0]        source_index;
        logic [INDEX_W-1:0]        target_index;
        logic signed [VALUE_W-1:0] write_value;
        logic [MASK_W-1:0]         fired_mask;
    } req_t;

    typedef struct packed {
        logic [INDEX_W-1:0]        neuron_index;
        logic signed [VALUE_W-1:0] drive_current;
        logic                      last;
    } rsp_t;

    typedef struct packed {
        logic               load_req;
        logic               w_rd;
        logic               w_wr;
        logic               b_wr;
        logic               b_rd;
        logic               acc_rd;
        logic               shift;
        logic               out_load;
        logic               tick_done;
        logic [INDEX_W-1:0] idx;
        logic [INDEX_W-1:0] b_addr;
    } ctrl_cmd_t;

    typedef struct packed {
        logic in_weight;
        logic in_bias;
        logic in_tick;
        logic out_free;
    } ctrl_sts_t;

    function automatic logic signed [VALUE_W-1:0] sat32(input logic signed [VALUE_W:0] v);
        logic signed [VALUE_W-1:0] r;
        if (v[VALUE_W] != v[VALUE_W-1])
        begin
            r = v[VALUE_W] ? {1'b1, {(VALUE_W-1){1'b0}}} : {1'b0, {(VALUE_W-1){1'b1}}};
        end
        else
        begin
            r = v[VALUE_W-1:0];
        end
        return r;
    endfunction

endpackage

### rtl/ssc_ram.sv
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps

module ssc_ram
    import ssc_pkg::*;
#(
    parameter int WIDTH = VALUE_W,
    parameter int DEPTH = NEURONS_DEF
)
(
    input  logic                                  clk,
    input  logic                                  we,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                      wdata,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/ssc_ctrl.sv
// Sequencer of the synaptic current engine: request decode, row sweep, drive sweep.
`timescale 1ns / 1ps

module ssc_ctrl
    import ssc_pkg::*;
#(
    parameter int NEURONS = NEURONS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  ctrl_sts_t sts,
    output ctrl_cmd_t cmd
);

    localparam int CNT_W = $clog2(NEURONS + 1);
    localparam logic [CNT_W-1:0] LAST_ROW = CNT_W'(NEURONS - 1);
    localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(NEURONS);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WRD   = 3'd1;
    localparam logic [2:0] S_WWR   = 3'd2;
    localparam logic [2:0] S_BWR   = 3'd3;
    localparam logic [2:0] S_ACC   = 3'd4;
    localparam logic [2:0] S_PRIME = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             accept;

    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.idx    = INDEX_W'(cnt_reg);
        cmd.b_addr = INDEX_W'(cnt_reg + 1'b1);
        unique case (state_reg)
            S_IDLE:
            begin
                cnt_next = '0;
                if (accept)
                begin
                    cmd.load_req = 1'b1;
                    priority if (sts.in_weight)
                    begin
                        state_next = S_WRD;
                    end
                    else if (sts.in_bias)
                    begin
                        state_next = S_BWR;
                    end
                    else if (sts.in_tick)
                    begin
                        state_next = S_ACC;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_WRD:
            begin
                cmd.w_rd   = 1'b1;
                state_next = S_WWR;
            end
            S_WWR:
            begin
                cmd.w_wr   = 1'b1;
                state_next = S_IDLE;
            end
            S_BWR:
            begin
                cmd.b_wr   = 1'b1;
                state_next = S_IDLE;
            end
            S_ACC:
            begin
                cmd.acc_rd = 1'b1;
                if (cnt_reg == LAST_ROW)
                begin
                    cnt_next   = '0;
                    state_next = S_PRIME;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_PRIME:
            begin
                cmd.b_rd   = 1'b1;
                cmd.b_addr = '0;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (cnt_reg != CNT_END)
                begin
                    if (sts.out_free)
                    begin
                        cmd.shift    = 1'b1;
                        cmd.out_load = 1'b1;
                        cmd.b_rd     = (cnt_reg != LAST_ROW);
                        cnt_next     = cnt_reg + 1'b1;
                    end
                end
                else
                begin
                    cmd.shift     = 1'b1;
                    cmd.tick_done = 1'b1;
                    cnt_next      = '0;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

### rtl/ssc_dp.sv
// Datapath of the synaptic current engine: stores, current lanes, decay unit, result register.
`timescale 1ns / 1ps

module ssc_dp
    import ssc_pkg::*;
#(
    parameter int NEURONS     = NEURONS_DEF,
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [PERIOD_W-1:0] cfg_wdata,
    input  req_t                req,
    input  ctrl_cmd_t           cmd,
    output ctrl_sts_t           sts,
    input  logic                rsp_stall,
    output logic                rsp_valid,
    output rsp_t                rsp
);

    localparam int IDX_W = (NEURONS > 1) ? $clog2(NEURONS) : 1;
    localparam int ROW_W = NEURONS * WEIGHT_BITS;
    localparam logic [INDEX_W:0] N_LIM = (INDEX_W + 1)'(NEURONS);
    localparam logic signed [VALUE_W:0] W_MAX =
        (VALUE_W + 1)'((64'sd1 <<< (WEIGHT_BITS - 1)) - 64'sd1);
    localparam logic signed [VALUE_W:0] W_MIN = -W_MAX - 1;

    req_t                      req_reg;
    logic [PERIOD_W-1:0]       decay_period_reg;
    logic [PERIOD_W-1:0]       tick_count_reg;
    logic [NEURONS-1:0]        row_valid_reg;
    logic [NEURONS-1:0]        bias_valid_reg;
    logic                      acc_pend_reg;
    logic                      acc_fire_reg;
    logic                      bias_vld_q_reg;
    logic signed [VALUE_W-1:0] cur_reg [NEURONS];
    logic [VALUE_W-1:0]        p_mag_reg;
    logic [DECAY_Q_W-1:0]      p_q_reg;
    logic                      p_neg_reg;
    logic signed [VALUE_W-1:0] p_raw_reg;
    rsp_t                      rsp_reg;
    logic                      rsp_valid_reg;

    logic [IDX_W-1:0]          src_i, tgt_i, cmd_i, w_addr, b_addr;
    logic [ROW_W-1:0]          w_rdata, w_row, w_wdata;
    logic [VALUE_W-1:0]        b_rdata;
    logic signed [VALUE_W:0]   wv, w_clamp;
    logic signed [VALUE_W-1:0] acc_sat [NEURONS];
    logic                      decay_now;
    logic [VALUE_W-1:0]        dec_mag_in, dec_b, dec_mag, dec_val;
    logic [2*VALUE_W-1:0]      dec_prod;
    logic signed [VALUE_W-1:0] dec_out, bias_eff, drive;

    // Request decode for the sequencer
    assign sts.in_weight = (req.func == FUNC_WEIGHT) &&
                           ({1'b0, req.source_index} < N_LIM) &&
                           ({1'b0, req.target_index} < N_LIM);
    assign sts.in_bias   = (req.func == FUNC_BIAS) && ({1'b0, req.target_index} < N_LIM);
    assign sts.in_tick   = (req.func == FUNC_TICK);
    assign sts.out_free  = !rsp_valid_reg || !rsp_stall;

    assign src_i = req_reg.source_index[IDX_W-1:0];
    assign tgt_i = req_reg.target_index[IDX_W-1:0];
    assign cmd_i = cmd.idx[IDX_W-1:0];

    // Weight store: one row per entry
    assign w_addr = cmd.acc_rd ? cmd_i : src_i;

    ssc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NEURONS)
    ) u_weight_ram (
        .clk   (clk),
        .we    (cmd.w_wr),
        .re    (cmd.w_rd || cmd.acc_rd),
        .addr  (w_addr),
        .wdata (w_wdata),
        .rdata (w_rdata)
    );

    // Clamp the weight and merge it into the row read back
    always_comb
    begin
        wv = (VALUE_W + 1)'(req_reg.write_value);
        priority if (wv > W_MAX)
        begin
            w_clamp = W_MAX;
        end
        else if (wv < W_MIN)
        begin
            w_clamp = W_MIN;
        end
        else
        begin
            w_clamp = wv;
        end
        w_row   = row_valid_reg[src_i] ? w_rdata : '0;
        w_wdata = w_row;
        w_wdata[tgt_i * WEIGHT_BITS +: WEIGHT_BITS] = w_clamp[WEIGHT_BITS-1:0];
    end

    // Bias store
    assign b_addr = cmd.b_wr ? tgt_i : cmd.b_addr[IDX_W-1:0];

    ssc_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (NEURONS)
    ) u_bias_ram (
        .clk   (clk),
        .we    (cmd.b_wr),
        .re    (cmd.b_rd),
        .addr  (b_addr),
        .wdata (req_reg.write_value),
        .rdata (b_rdata)
    );

    // Lane-parallel saturating add of one weight row
    always_comb
    begin
        logic signed [WEIGHT_BITS-1:0] lane_w;
        for (int j = 0; j < NEURONS; j++)
        begin
            lane_w     = $signed(w_rdata[j * WEIGHT_BITS +: WEIGHT_BITS]);
            acc_sat[j] = sat32((VALUE_W + 1)'(cur_reg[j]) + (VALUE_W + 1)'(lane_w));
        end
    end

    // Decay unit: multiply stage, then subtract and restore sign
    assign decay_now  = (tick_count_reg >= decay_period_reg);
    assign dec_mag_in = cur_reg[0][VALUE_W-1] ? (VALUE_W'(0) - $unsigned(cur_reg[0]))
                                              : $unsigned(cur_reg[0]);
    assign dec_b      = dec_mag_in + DECAY_ROUND;
    assign dec_prod   = (2 * VALUE_W)'(dec_b) * (2 * VALUE_W)'(DECAY_RECIP);
    assign dec_mag    = p_mag_reg - VALUE_W'(p_q_reg);
    assign dec_val    = p_neg_reg ? (VALUE_W'(0) - dec_mag) : dec_mag;
    assign dec_out    = decay_now ? $signed(dec_val) : p_raw_reg;

    // Drive of the neuron at the head of the ring
    assign bias_eff = bias_vld_q_reg ? $signed(b_rdata) : '0;
    assign drive    = sat32((VALUE_W + 1)'(cur_reg[0]) + (VALUE_W + 1)'(bias_eff));

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg <= req;
        end
        if (cmd.shift)
        begin
            p_mag_reg <= dec_mag_in;
            p_q_reg   <= dec_prod[2*VALUE_W-1:DECAY_SHIFT];
            p_neg_reg <= cur_reg[0][VALUE_W-1];
            p_raw_reg <= cur_reg[0];
        end
        if (cmd.out_load)
        begin
            rsp_reg.neuron_index  <= cmd.idx;
            rsp_reg.drive_current <= drive;
            rsp_reg.last          <= (cmd.idx == INDEX_W'(NEURONS - 1));
        end
        if (cmd.acc_rd)
        begin
            acc_fire_reg <= req_reg.fired_mask[cmd_i] && row_valid_reg[cmd_i];
        end
        if (cmd.b_rd)
        begin
            bias_vld_q_reg <= bias_valid_reg[b_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_period_reg <= PERIOD_W'(1);
            tick_count_reg   <= '0;
            row_valid_reg    <= '0;
            bias_valid_reg   <= '0;
            acc_pend_reg     <= 1'b0;
            rsp_valid_reg    <= 1'b0;
            for (int j = 0; j < NEURONS; j++)
            begin
                cur_reg[j] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                decay_period_reg <= cfg_wdata;
            end
            if (cmd.tick_done)
            begin
                tick_count_reg <= decay_now ? PERIOD_W'(1) : tick_count_reg + 1'b1;
            end
            if (cmd.w_wr)
            begin
                row_valid_reg[src_i] <= 1'b1;
            end
            if (cmd.b_wr)
            begin
                bias_valid_reg[tgt_i] <= 1'b1;
            end
            acc_pend_reg <= cmd.acc_rd;
            if (cmd.out_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (acc_pend_reg && acc_fire_reg)
            begin
                for (int j = 0; j < NEURONS; j++)
                begin
                    cur_reg[j] <= acc_sat[j];
                end
            end
            else if (cmd.shift)
            begin
                for (int j = 0; j < NEURONS - 1; j++)
                begin
                    cur_reg[j] <= cur_reg[j + 1];
                end
                cur_reg[NEURONS-1] <= dec_out;
            end
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

### rtl/spiking_synapse_current_update.sv
// Top level of the synaptic current engine for a spiking network.
//
//   channel   direction  handshake              payload
//   request   in         req_valid / req_stall  req (req_t)
//   result    out        rsp_valid / rsp_stall  rsp (rsp_t)
//   config    in         cfg_we                 cfg_wdata (decay period)
//
// A weight write passes through accept, row read and row write back, a bias
// write through accept and bias write, an ignored request through accept only.
// A tick accepts, reads one weight row per cycle from the row wide weight RAM,
// primes the bias RAM, then emits one drive per cycle, while the result is free,
// through the rotating current ring and its two-stage decay unit.
// Reset clears control, currents and valid bits of both stores at once; no
// clearing pass is needed. A stalled result holds the drive sweep in place.
`timescale 1ns / 1ps

`include "spiking_synapse_current_update_defines.svh"

module spiking_synapse_current_update
    import ssc_pkg::*;
#(
    parameter int NEURONS     = NEURONS_DEF,
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [PERIOD_W-1:0] cfg_wdata,
    input  logic                req_valid,
    output logic                req_stall,
    input  req_t                req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output rsp_t                rsp
);

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    // Sequencer: owns the row and neuron counter, issues one command set per cycle
    ssc_ctrl #(
        .NEURONS (NEURONS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Datapath: weight and bias RAMs, current lanes, decay unit, result register
    ssc_dp #(
        .NEURONS     (NEURONS),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

    // Never overwrite a result that is still waiting
    `SSC_ASSERT_NOW(a_load_free, cmd.out_load, sts.out_free, "result overwritten")
    // Return to idle right after the drive sweep ends
    `SSC_ASSERT_NEXT(a_idle_after_tick, cmd.tick_done, !req_stall, "not idle after tick")
    // Drives leave in neuron order within a tick
    `SSC_ASSERT_NEXT(a_index_order, rsp_valid && !rsp_stall && !rsp.last,
        !rsp_valid || rsp.neuron_index == INDEX_W'($past(rsp.neuron_index) + 1'b1),
        "drive out of order")

endmodule
